[rtl/itrt_pkg.sv]
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared constants, microcode types and the digit glyph function for the
// integer to radix text converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned IdxW     = $clog2(WordBits);
  localparam int unsigned CntW     = $clog2(WordBits) + 1;
  localparam int unsigned RadixW   = 6;
  localparam int unsigned DigitW   = 6;
  localparam int unsigned CharW    = 7;
  localparam int unsigned InDataW  = ((WordBits + RadixW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((CharW + 7) / 8) * 8;
  localparam int unsigned UpcW     = 4;

  localparam logic [RadixW-1:0] RadixMin = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax = RadixW'(36);
  localparam logic [RadixW-1:0] RadixDec = RadixW'(10);

  localparam logic [CharW-1:0] CharMinus = 7'h2d;
  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharLowA  = 7'h61;

  typedef enum logic [3:0] {
    ActNop,
    ActAccept,
    ActNegate,
    ActEmitMinus,
    ActDivStart,
    ActDivStore,
    ActRead,
    ActEmitDigit,
    ActEmitBad
  } act_e;

  typedef enum logic [3:0] {
    CondNext,
    CondJump,
    CondNoInput,
    CondBad,
    CondNotNeg10,
    CondDivBusy,
    CondMoreDigits,
    CondOutFull,
    CondCntNz
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [UpcW-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic bad_radix;
    logic neg10;
    logic div_busy;
    logic more_digits;
    logic out_full;
    logic cnt_nz;
  } status_t;

  function automatic logic [CharW-1:0] glyph(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DigitW'(10)) begin
      c = CharZero + CharW'(d);
    end else if (d < DigitW'(36)) begin
      c = CharLowA + CharW'(d - DigitW'(10));
    end else begin
      c = CharZero;
    end
    return c;
  endfunction

endpackage

[rtl/itrt_divider.sv]
// ----------------------------------------------------------------------------
// itrt_divider
// Restoring divider: one quotient bit per cycle, word by radix.
// ----------------------------------------------------------------------------
module itrt_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [itrt_pkg::WordBits-1:0] dividend_i,
  input  logic [itrt_pkg::RadixW-1:0]   divisor_i,
  output logic                          busy_o,
  output logic [itrt_pkg::WordBits-1:0] quot_o,
  output logic [itrt_pkg::DigitW-1:0]   rem_o
);

  logic                          busy_q;
  logic [itrt_pkg::IdxW-1:0]     step_q;
  logic [itrt_pkg::WordBits-1:0] quo_q, quo_d;
  logic [itrt_pkg::DigitW-1:0]   rem_q, rem_d;
  logic [itrt_pkg::DigitW:0]     trial;
  logic                          ge;

  // The partial remainder stays below the divisor, so six bits plus the
  // incoming dividend bit are enough for the trial value.
  always_comb begin
    trial = {rem_q, quo_q[itrt_pkg::WordBits-1]};
    ge    = trial >= {1'b0, divisor_i};
    rem_d = ge ? itrt_pkg::DigitW'(trial - {1'b0, divisor_i})
               : itrt_pkg::DigitW'(trial);
    quo_d = {quo_q[itrt_pkg::WordBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= itrt_pkg::IdxW'(itrt_pkg::WordBits - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[rtl/itrt_datapath.sv]
// ----------------------------------------------------------------------------
// itrt_datapath
// Operand registers, digit buffer, digit counter and output register,
// driven by one control word per cycle.
// ----------------------------------------------------------------------------
module itrt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itrt_pkg::act_e                act_i,
  input  logic                          in_valid_i,
  input  logic [itrt_pkg::WordBits-1:0] value_i,
  input  logic [itrt_pkg::RadixW-1:0]   radix_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [itrt_pkg::CharW-1:0]    out_char_o,
  output logic                          out_last_o,
  output logic                          out_bad_o,
  output itrt_pkg::status_t             status_o
);

  logic [itrt_pkg::WordBits-1:0] mag_q;
  logic [itrt_pkg::RadixW-1:0]   radix_q;
  logic [itrt_pkg::CntW-1:0]     cnt_q;
  logic [itrt_pkg::DigitW-1:0]   digit_buf [itrt_pkg::WordBits];
  logic [itrt_pkg::DigitW-1:0]   rd_q;
  logic                          out_valid_q;
  logic [itrt_pkg::CharW-1:0]    out_char_q;
  logic                          out_last_q;
  logic                          out_bad_q;
  logic                          out_full;
  logic                          emit_go;
  logic                          div_busy;
  logic [itrt_pkg::WordBits-1:0] quot;
  logic [itrt_pkg::DigitW-1:0]   rem;
  logic [itrt_pkg::CntW-1:0]     cnt_dec;

  itrt_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (act_i == itrt_pkg::ActDivStart),
    .dividend_i(mag_q),
    .divisor_i (radix_q),
    .busy_o    (div_busy),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  // The output word may be replaced in the cycle it is taken.
  assign out_full = out_valid_q && !out_ready_i;
  assign emit_go  = !out_full && (act_i inside {itrt_pkg::ActEmitMinus,
                                                itrt_pkg::ActEmitDigit,
                                                itrt_pkg::ActEmitBad});
  assign cnt_dec  = cnt_q - 1'b1;

  always_comb begin
    status_o.in_valid    = in_valid_i;
    status_o.bad_radix   = (radix_q < itrt_pkg::RadixMin) || (radix_q > itrt_pkg::RadixMax);
    status_o.neg10       = mag_q[itrt_pkg::WordBits-1] && (radix_q == itrt_pkg::RadixDec);
    status_o.div_busy    = div_busy;
    status_o.more_digits = (mag_q != '0) && (cnt_q != itrt_pkg::CntW'(itrt_pkg::WordBits));
    status_o.out_full    = out_full;
    status_o.cnt_nz      = cnt_q != '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (act_i)
        itrt_pkg::ActAccept: begin
          cnt_q <= '0;
        end
        itrt_pkg::ActDivStore: begin
          cnt_q <= cnt_q + 1'b1;
        end
        itrt_pkg::ActRead: begin
          cnt_q <= cnt_dec;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (act_i)
      itrt_pkg::ActAccept: begin
        if (in_valid_i) begin
          mag_q   <= value_i;
          radix_q <= radix_i;
        end
      end
      itrt_pkg::ActNegate: begin
        if (status_o.neg10) begin
          mag_q <= ~mag_q + 1'b1;
        end
      end
      itrt_pkg::ActDivStore: begin
        mag_q                            <= quot;
        digit_buf[cnt_q[itrt_pkg::IdxW-1:0]] <= rem;
      end
      itrt_pkg::ActRead: begin
        rd_q <= digit_buf[cnt_dec[itrt_pkg::IdxW-1:0]];
      end
      itrt_pkg::ActEmitMinus: begin
        if (!out_full) begin
          out_char_q <= itrt_pkg::CharMinus;
          out_last_q <= 1'b0;
          out_bad_q  <= 1'b0;
        end
      end
      itrt_pkg::ActEmitDigit: begin
        if (!out_full) begin
          out_char_q <= itrt_pkg::glyph(rd_q);
          out_last_q <= cnt_q == '0;
          out_bad_q  <= 1'b0;
        end
      end
      itrt_pkg::ActEmitBad: begin
        if (!out_full) begin
          out_char_q <= '0;
          out_last_q <= 1'b1;
          out_bad_q  <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_bad_o   = out_bad_q;

endmodule

[rtl/itrt_sequencer.sv]
// ----------------------------------------------------------------------------
// itrt_sequencer
// Microprogram counter and control store. Each step issues one control
// word; its condition selects between the next step and the jump target.
// ----------------------------------------------------------------------------
module itrt_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  itrt_pkg::status_t status_i,
  output itrt_pkg::act_e    act_o
);

  localparam logic [itrt_pkg::UpcW-1:0] StepIdle    = 4'd0;
  localparam logic [itrt_pkg::UpcW-1:0] StepDivide  = 4'd4;
  localparam logic [itrt_pkg::UpcW-1:0] StepWait    = 4'd5;
  localparam logic [itrt_pkg::UpcW-1:0] StepRead    = 4'd8;
  localparam logic [itrt_pkg::UpcW-1:0] StepEmit    = 4'd9;
  localparam logic [itrt_pkg::UpcW-1:0] StepBad     = 4'd12;
  localparam logic [itrt_pkg::UpcW-1:0] StepMinus   = 4'd3;

  logic [itrt_pkg::UpcW-1:0] upc_q, upc_d;
  itrt_pkg::uword_t          uw;
  logic                      taken;

  function automatic itrt_pkg::uword_t ucode(input logic [itrt_pkg::UpcW-1:0] pc);
    itrt_pkg::uword_t w;
    unique case (pc)
      4'd0:  w = '{itrt_pkg::ActAccept,    itrt_pkg::CondNoInput,    StepIdle};
      4'd1:  w = '{itrt_pkg::ActNop,       itrt_pkg::CondBad,        StepBad};
      4'd2:  w = '{itrt_pkg::ActNegate,    itrt_pkg::CondNotNeg10,   StepDivide};
      4'd3:  w = '{itrt_pkg::ActEmitMinus, itrt_pkg::CondOutFull,    StepMinus};
      4'd4:  w = '{itrt_pkg::ActDivStart,  itrt_pkg::CondNext,       StepIdle};
      4'd5:  w = '{itrt_pkg::ActNop,       itrt_pkg::CondDivBusy,    StepWait};
      4'd6:  w = '{itrt_pkg::ActDivStore,  itrt_pkg::CondNext,       StepIdle};
      4'd7:  w = '{itrt_pkg::ActNop,       itrt_pkg::CondMoreDigits, StepDivide};
      4'd8:  w = '{itrt_pkg::ActRead,      itrt_pkg::CondNext,       StepIdle};
      4'd9:  w = '{itrt_pkg::ActEmitDigit, itrt_pkg::CondOutFull,    StepEmit};
      4'd10: w = '{itrt_pkg::ActNop,       itrt_pkg::CondCntNz,      StepRead};
      4'd11: w = '{itrt_pkg::ActNop,       itrt_pkg::CondJump,       StepIdle};
      4'd12: w = '{itrt_pkg::ActEmitBad,   itrt_pkg::CondOutFull,    StepBad};
      4'd13: w = '{itrt_pkg::ActNop,       itrt_pkg::CondJump,       StepIdle};
      default: w = '{itrt_pkg::ActNop,     itrt_pkg::CondJump,       StepIdle};
    endcase
    return w;
  endfunction

  always_comb begin
    uw = ucode(upc_q);
    unique case (uw.cond)
      itrt_pkg::CondNext:       taken = 1'b0;
      itrt_pkg::CondJump:       taken = 1'b1;
      itrt_pkg::CondNoInput:    taken = !status_i.in_valid;
      itrt_pkg::CondBad:        taken = status_i.bad_radix;
      itrt_pkg::CondNotNeg10:   taken = !status_i.neg10;
      itrt_pkg::CondDivBusy:    taken = status_i.div_busy;
      itrt_pkg::CondMoreDigits: taken = status_i.more_digits;
      itrt_pkg::CondOutFull:    taken = status_i.out_full;
      itrt_pkg::CondCntNz:      taken = status_i.cnt_nz;
      default:                  taken = 1'b0;
    endcase
    upc_d = taken ? uw.target : upc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= StepIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign act_o = uw.act;

endmodule

[rtl/integer_to_radix_text_top.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_text_top
// Converts a 32-bit value to ASCII digits in base 2 to 36, most significant
// first, one character per output word.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_axis   in         tdata = value[31:0], radix[37:32], zero fill to 40 bits
//  m_axis   out        tdata = out_char[6:0], zero bit 7; tlast = last;
//                      tuser = bad_radix
//
//  One word is converted at a time. Each digit costs one pass of the
//  bit-serial divider; once all digits are stored, each character is
//  read from the digit buffer and emitted in turn. A bad radix skips
//  the divider and emits one error word. Reset returns the microprogram
//  counter to its wait step and empties the output register; the digit
//  buffer is not cleared. A stalled output holds the sequencer on its
//  emit step; the last word of a conversion may wait in the output
//  register while the next input word is accepted.
// ----------------------------------------------------------------------------
module integer_to_radix_text_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [itrt_pkg::InDataW-1:0]  s_axis_tdata_i,   // value, radix
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [itrt_pkg::OutDataW-1:0] m_axis_tdata_o,   // out_char
  output logic                          m_axis_tlast_o,
  output logic                          m_axis_tuser_o    // bad_radix
);

  itrt_pkg::act_e                 act;
  itrt_pkg::status_t              status;
  logic [itrt_pkg::CharW-1:0]     out_char;
  logic                           accept;

  assign s_axis_tready_o = act == itrt_pkg::ActAccept;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  itrt_sequencer u_sequencer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .act_o   (act)
  );

  itrt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .act_i      (act),
    .in_valid_i (accept),
    .value_i    (s_axis_tdata_i[itrt_pkg::WordBits-1:0]),
    .radix_i    (s_axis_tdata_i[itrt_pkg::WordBits +: itrt_pkg::RadixW]),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_char_o (out_char),
    .out_last_o (m_axis_tlast_o),
    .out_bad_o  (m_axis_tuser_o),
    .status_o   (status)
  );

  assign m_axis_tdata_o = itrt_pkg::OutDataW'(out_char);

endmodule

[sim/itrt_checker.sv]
// ----------------------------------------------------------------------------
// itrt_checker
// Watches both stream channels of the integer to radix text converter. It
// predicts the characters for every accepted input word, compares each
// output word with the oldest prediction, and counts the mismatches.
// ----------------------------------------------------------------------------
module itrt_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [itrt_pkg::InDataW-1:0]  s_axis_tdata_i,   // value, radix
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [itrt_pkg::OutDataW-1:0] m_axis_tdata_i,   // out_char
  input  logic                          m_axis_tlast_i,
  input  logic                          m_axis_tuser_i,   // bad_radix
  input  logic                          drain_done_i,
  output int unsigned                   pending_chars_o,
  output int unsigned                   words_in_o,
  output int unsigned                   chars_out_o,
  output int unsigned                   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [itrt_pkg::CharW-1:0] ch;
    logic                       last;
    logic                       bad_radix;
  } text_char_t;

  text_char_t expected_text[$];
  bit         leftovers_checked = 1'b0;

  initial begin
    pending_chars_o = 0;
    words_in_o      = 0;
    chars_out_o     = 0;
    fail_count_o    = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("itrt_checker: %s mismatch at char %0d: expected 0x%0h, got 0x%0h",
             what, chars_out_o, want, got);
    fail_count_o = fail_count_o + 1;
  endtask

  function automatic logic [itrt_pkg::CharW-1:0] digit_char(
      input logic [itrt_pkg::DigitW-1:0] d);
    if (d < itrt_pkg::DigitW'(10)) begin
      return itrt_pkg::CharZero + itrt_pkg::CharW'(d);
    end
    return itrt_pkg::CharLowA + itrt_pkg::CharW'(d - itrt_pkg::DigitW'(10));
  endfunction

  // Appends the characters one conversion yields, most significant first.
  function automatic void predict_text(input logic [itrt_pkg::WordBits-1:0] value,
                                       input logic [itrt_pkg::RadixW-1:0] radix);
    logic [itrt_pkg::WordBits-1:0] mag;
    logic [itrt_pkg::DigitW-1:0]   digits [itrt_pkg::WordBits];
    int                            n;
    text_char_t                    c;
    if (radix < itrt_pkg::RadixMin || radix > itrt_pkg::RadixMax) begin
      c = '{ch: '0, last: 1'b1, bad_radix: 1'b1};
      expected_text.push_back(c);
      return;
    end
    mag = value;
    // Only base 10 is signed; other bases print the raw pattern.
    if (radix == itrt_pkg::RadixDec && value[itrt_pkg::WordBits-1]) begin
      mag = ~value + 1'b1;
      c = '{ch: itrt_pkg::CharMinus, last: 1'b0, bad_radix: 1'b0};
      expected_text.push_back(c);
    end
    n = 0;
    do begin
      digits[n] = itrt_pkg::DigitW'(mag % itrt_pkg::WordBits'(radix));
      mag = mag / itrt_pkg::WordBits'(radix);
      n++;
    end while (mag != 0 && n < itrt_pkg::WordBits);
    for (int i = n - 1; i >= 0; i--) begin
      c = '{ch: digit_char(digits[i]), last: (i == 0), bad_radix: 1'b0};
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_text(s_axis_tdata_i[itrt_pkg::WordBits-1:0],
                     s_axis_tdata_i[itrt_pkg::WordBits +: itrt_pkg::RadixW]);
        words_in_o <= words_in_o + 1;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected word", 0, 32'(m_axis_tdata_i));
        end else begin
          want = expected_text.pop_front();
          // The padding bit above the character must stay zero.
          if (m_axis_tdata_i !== itrt_pkg::OutDataW'(want.ch)) begin
            report_mismatch("out_char", 32'(want.ch), 32'(m_axis_tdata_i));
          end
          if (m_axis_tlast_i !== want.last) begin
            report_mismatch("last", 32'(want.last), 32'(m_axis_tlast_i));
          end
          if (m_axis_tuser_i !== want.bad_radix) begin
            report_mismatch("bad_radix", 32'(want.bad_radix), 32'(m_axis_tuser_i));
          end
        end
        chars_out_o <= chars_out_o + 1;
      end
      if (drain_done_i && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_text.size() != 0) begin
          report_mismatch("missing words", 0, unsigned'(expected_text.size()));
        end
      end
    end
    pending_chars_o <= unsigned'(expected_text.size());
  end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives value and radix words into the integer to radix text converter,
// directed corner cases first and then a random mix, with random gaps and
// output stalls. Checking is done by itrt_checker; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned RandomWords = 290;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [itrt_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [itrt_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          m_axis_tuser;
  logic                          drain_done = 1'b0;

  int unsigned pending_chars;
  int unsigned words_in;
  int unsigned chars_out;
  int unsigned fail_count;
  int unsigned stall_cycles = 0;
  int unsigned bad_radix_words = 0;
  int unsigned neg_decimal_words = 0;
  bit          idle_on = 1'b1;

  always #6 clk_i = ~clk_i;

  integer_to_radix_text_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  itrt_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .m_axis_tuser_i  (m_axis_tuser),
    .drain_done_i    (drain_done),
    .pending_chars_o (pending_chars),
    .words_in_o      (words_in),
    .chars_out_o     (chars_out),
    .fail_count_o    (fail_count)
  );

  // Receiver stalls about one cycle in ten while idling is enabled.
  always @(posedge clk_i) begin
    m_axis_tready <= idle_on ? ($urandom_range(99) >= 10) : 1'b1;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("tb: no handshake for %0d cycles", StallLimit);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // tvalid stays high between back-to-back words; within this task it only drops for a gap.
  task automatic send_word(input logic [itrt_pkg::WordBits-1:0] value,
                           input logic [itrt_pkg::RadixW-1:0] radix);
    if (idle_on && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= itrt_pkg::InDataW'({radix, value});
    if (radix < itrt_pkg::RadixMin || radix > itrt_pkg::RadixMax) begin
      bad_radix_words++;
    end else if (radix == itrt_pkg::RadixDec && value[itrt_pkg::WordBits-1]) begin
      neg_decimal_words++;
    end
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_for_text;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_chars != 0);
  endtask

  initial begin
    logic [itrt_pkg::WordBits-1:0] value;
    logic [itrt_pkg::RadixW-1:0]   radix;
    int unsigned                   pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(32'd0, 6'd10);
    send_word(32'd0, 6'd2);
    send_word(32'd1, 6'd36);
    send_word(32'd9, 6'd10);
    send_word(32'd10, 6'd36);
    send_word(32'd35, 6'd36);
    send_word(32'd36, 6'd36);
    send_word(32'hffff_ffff, 6'd10);
    send_word(32'hffff_ffff, 6'd2);
    send_word(32'hffff_ffff, 6'd16);
    send_word(32'hffff_ffff, 6'd36);
    send_word(32'h8000_0000, 6'd10);
    send_word(32'h8000_0000, 6'd16);
    send_word(32'h7fff_ffff, 6'd10);
    send_word(32'h7fff_ffff, 6'd36);
    send_word(-32'sd12345, 6'd10);
    send_word(-32'sd12345, 6'd16);
    send_word(32'd12345, 6'd8);
    send_word(32'hdead_beef, 6'd3);
    send_word(32'd255, 6'd2);
    send_word(32'd100, 6'd0);
    send_word(32'd100, 6'd1);
    send_word(32'd100, 6'd37);
    send_word(32'hffff_ffff, 6'd63);
    wait_for_text();

    for (int i = 0; i < RandomWords; i++) begin
      // A stretch in the middle runs with no gaps and no stalls.
      idle_on = !(i >= 120 && i < 200);
      pick = $urandom_range(99);
      if (pick < 10) begin
        radix = $urandom_range(1) ? itrt_pkg::RadixW'($urandom_range(37, 63))
                                  : itrt_pkg::RadixW'($urandom_range(0, 1));
      end else if (pick < 35) begin
        radix = itrt_pkg::RadixDec;
      end else if (pick < 45) begin
        radix = 6'd2;
      end else if (pick < 55) begin
        radix = 6'd16;
      end else begin
        radix = itrt_pkg::RadixW'($urandom_range(2, 36));
      end
      case ($urandom_range(3))
        0: value = $urandom;
        1: value = $urandom_range(0, 999);
        2: value = -$urandom_range(1, 999);
        default: begin
          case ($urandom_range(3))
            0: value = 32'h8000_0000 + $urandom_range(0, 3);
            1: value = 32'h7fff_ffff - $urandom_range(0, 3);
            2: value = $urandom_range(0, 3);
            default: value = 32'hffff_ffff - $urandom_range(0, 3);
          endcase
        end
      endcase
      send_word(value, radix);
      if (i % 97 == 96) begin
        wait_for_text();
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_chars != 0);
    repeat (100) @(posedge clk_i);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("tb: %0d words converted into %0d characters", words_in, chars_out);
    $display("tb: %0d with a bad radix, %0d negative in base 10",
             bad_radix_words, neg_decimal_words);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
